FILE: sv/cdfir_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the complex decimating FIR: field widths, accumulator
// sizing, register indexes and item mode codes. No dependencies.
package cdfir_pkg;

  localparam int unsigned MAX_TAPS  = 64;
  localparam int unsigned TAP_W     = 6;   // address into the tap stores
  localparam int unsigned CNT_W     = 7;   // counts 0..MAX_TAPS
  localparam int unsigned MAX_DECIM = 16;
  localparam int unsigned DECIM_W   = 5;
  localparam int unsigned PHASE_W   = 4;
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned COEF_W    = 18;
  localparam int unsigned PROD_W    = SAMPLE_W + COEF_W;
  localparam int unsigned ACC_W     = PROD_W + TAP_W;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DECIM = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAPS  = 2'd1;

  // item mode codes
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_COEF   = 1'b1;

  localparam logic [DECIM_W-1:0] DECIM_RESET = 5'd1;
  localparam logic [CNT_W-1:0]   TAPS_RESET  = 7'd64;

  // rounding: add half an LSB of the Q1.17 product scale, then floor
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (COEF_W - 2);
  localparam logic signed [ACC_W-1:0] OUT_MAX    = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] OUT_MIN    = -ACC_W'(32768);

endpackage

FILE: sv/complex_decimating_fir.sv
`timescale 1ns / 1ps
// Complex decimating FIR with one shared multiply-accumulate unit (real coefficients, I and Q).
// Depends on cdfir_pkg for widths, register indexes and mode codes.
//
//   channel | handshake                 | payload
//   --------+---------------------------+--------------------------------------------
//   in      | in_valid_i / in_ready_o   | mode_i, sample_i_i, sample_q_i,
//           |                           | coef_index_i, coef_value_i
//   out     | out_valid_o / out_ready_i | out_i_o, out_q_o, saturated_o
//   cfg     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// A coefficient beat or a sample beat that yields no output leaves the sequencer
// idle. A sample beat that completes a decimation period runs the shared MAC over
// the taps in use, one tap per cycle through a read, multiply and accumulate
// stage, as there is a single MAC and one read port per store. Reset clears the
// stores logically through a fill count for the delay line and one valid bit
// per coefficient. A stalled output beat holds the sequencer in its final state;
// cfg writes are taken at any time.
module complex_decimating_fir (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_ready_o,
  input  logic                                     mode_i,
  input  logic signed [cdfir_pkg::SAMPLE_W-1:0]    sample_i_i,
  input  logic signed [cdfir_pkg::SAMPLE_W-1:0]    sample_q_i,
  input  logic        [cdfir_pkg::TAP_W-1:0]       coef_index_i,
  input  logic signed [cdfir_pkg::COEF_W-1:0]      coef_value_i,
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output logic signed [cdfir_pkg::SAMPLE_W-1:0]    out_i_o,
  output logic signed [cdfir_pkg::SAMPLE_W-1:0]    out_q_o,
  output logic                                     saturated_o,
  input  logic                                     cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  logic        [cdfir_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic        [cdfir_pkg::CFG_DAT_W-1:0]   cfg_data_i
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0] state_q, state_d;

  logic [cdfir_pkg::DECIM_W-1:0] decim_q;
  logic [cdfir_pkg::CNT_W-1:0]   taps_cfg_q;
  logic [cdfir_pkg::DECIM_W-1:0] decim_eff;
  logic [cdfir_pkg::CNT_W-1:0]   taps_eff;

  logic [cdfir_pkg::PHASE_W-1:0] phase_q, phase_d;
  logic [cdfir_pkg::DECIM_W-1:0] phase_inc;
  logic [cdfir_pkg::TAP_W-1:0]   wp_q, wp_d;
  logic [cdfir_pkg::CNT_W-1:0]   fill_q, fill_d;
  logic [cdfir_pkg::CNT_W-1:0]   k_q, k_d;
  logic [cdfir_pkg::MAX_TAPS-1:0] coef_vld_q;

  logic in_acc, samp_acc, coef_acc, fire, issue;
  logic [cdfir_pkg::TAP_W-1:0] rd_ptr;

  // tap stores
  logic signed [cdfir_pkg::SAMPLE_W-1:0] dly_i_mem [cdfir_pkg::MAX_TAPS];
  logic signed [cdfir_pkg::SAMPLE_W-1:0] dly_q_mem [cdfir_pkg::MAX_TAPS];
  logic signed [cdfir_pkg::COEF_W-1:0]   coef_mem  [cdfir_pkg::MAX_TAPS];

  // MAC pipeline
  logic                                  s1_q, s1_cv_q, s1_dv_q, s2_q;
  logic signed [cdfir_pkg::SAMPLE_W-1:0] rd_i_q, rd_q_q;
  logic signed [cdfir_pkg::COEF_W-1:0]   rd_c_q;
  logic signed [cdfir_pkg::SAMPLE_W-1:0] mul_i, mul_q;
  logic signed [cdfir_pkg::COEF_W-1:0]   mul_c;
  logic signed [cdfir_pkg::PROD_W-1:0]   prod_i_q, prod_q_q;
  logic signed [cdfir_pkg::ACC_W-1:0]    acc_i_q, acc_q_q;

  // rounding and output
  logic signed [cdfir_pkg::ACC_W-1:0]    rnd_i, rnd_q;
  logic                                  clip_i, clip_q, finish;
  logic signed [cdfir_pkg::SAMPLE_W-1:0] res_i, res_q;
  logic                                  out_vld_q;
  logic signed [cdfir_pkg::SAMPLE_W-1:0] out_i_q, out_q_q;
  logic                                  sat_q;

  // ---------------------------------------------------------------- config
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decim_q    <= cdfir_pkg::DECIM_RESET;
      taps_cfg_q <= cdfir_pkg::TAPS_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        cdfir_pkg::CFG_DECIM: decim_q    <= cfg_data_i[cdfir_pkg::DECIM_W-1:0];
        cdfir_pkg::CFG_TAPS:  taps_cfg_q <= cfg_data_i[cdfir_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (decim_q == '0) begin
      decim_eff = cdfir_pkg::DECIM_W'(1);
    end else if (decim_q > cdfir_pkg::DECIM_W'(cdfir_pkg::MAX_DECIM)) begin
      decim_eff = cdfir_pkg::DECIM_W'(cdfir_pkg::MAX_DECIM);
    end else begin
      decim_eff = decim_q;
    end
    if (taps_cfg_q > cdfir_pkg::CNT_W'(cdfir_pkg::MAX_TAPS)) begin
      taps_eff = cdfir_pkg::CNT_W'(cdfir_pkg::MAX_TAPS);
    end else begin
      taps_eff = taps_cfg_q;
    end
  end

  // -------------------------------------------------------------- sequencer
  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign samp_acc   = in_acc && (mode_i == cdfir_pkg::MODE_SAMPLE);
  assign coef_acc   = in_acc && (mode_i == cdfir_pkg::MODE_COEF);
  assign phase_inc  = {1'b0, phase_q} + cdfir_pkg::DECIM_W'(1);
  assign fire       = samp_acc && !(phase_inc < decim_eff);
  assign issue      = (state_q == S_RUN);
  assign finish     = (state_q == S_DRAIN) && !s1_q && !s2_q &&
                      (!out_vld_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    wp_d    = wp_q;
    fill_d  = fill_q;
    k_d     = k_q;
    if (samp_acc) begin
      wp_d = wp_q + cdfir_pkg::TAP_W'(1);
      if (fill_q != cdfir_pkg::CNT_W'(cdfir_pkg::MAX_TAPS)) begin
        fill_d = fill_q + cdfir_pkg::CNT_W'(1);
      end
      if (fire) begin
        phase_d = '0;
      end else begin
        phase_d = phase_inc[cdfir_pkg::PHASE_W-1:0];
      end
    end
    unique case (state_q)
      S_IDLE: begin
        if (fire) begin
          k_d     = '0;
          state_d = (taps_eff == '0) ? S_DRAIN : S_RUN;
        end
      end
      S_RUN: begin
        k_d = k_q + cdfir_pkg::CNT_W'(1);
        if (k_d == taps_eff) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (finish) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      phase_q    <= '0;
      wp_q       <= '0;
      fill_q     <= '0;
      k_q        <= '0;
      coef_vld_q <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      wp_q    <= wp_d;
      fill_q  <= fill_d;
      k_q     <= k_d;
      if (coef_acc) begin
        coef_vld_q[coef_index_i] <= 1'b1;
      end
    end
  end

  // ----------------------------------------------------------------- stores
  // newest sample sits at wp_q; tap k lives k entries behind it
  assign rd_ptr = wp_q - k_q[cdfir_pkg::TAP_W-1:0];

  always_ff @(posedge clk_i) begin
    if (samp_acc) begin
      dly_i_mem[wp_d] <= sample_i_i;
      dly_q_mem[wp_d] <= sample_q_i;
    end
    rd_i_q <= dly_i_mem[rd_ptr];
    rd_q_q <= dly_q_mem[rd_ptr];
  end

  always_ff @(posedge clk_i) begin
    if (coef_acc) begin
      coef_mem[coef_index_i] <= coef_value_i;
    end
    rd_c_q <= coef_mem[k_q[cdfir_pkg::TAP_W-1:0]];
  end

  // -------------------------------------------------------------- MAC unit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q    <= 1'b0;
      s2_q    <= 1'b0;
      s1_cv_q <= 1'b0;
      s1_dv_q <= 1'b0;
    end else begin
      s1_q    <= issue;
      s2_q    <= s1_q;
      s1_cv_q <= coef_vld_q[k_q[cdfir_pkg::TAP_W-1:0]];
      s1_dv_q <= (k_q < fill_q);
    end
  end

  // never-written entries read as zero
  assign mul_c = s1_cv_q ? rd_c_q : '0;
  assign mul_i = s1_dv_q ? rd_i_q : '0;
  assign mul_q = s1_dv_q ? rd_q_q : '0;

  always_ff @(posedge clk_i) begin
    prod_i_q <= mul_c * mul_i;
    prod_q_q <= mul_c * mul_q;
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      acc_i_q <= '0;
      acc_q_q <= '0;
    end else if (s2_q) begin
      acc_i_q <= acc_i_q + {{cdfir_pkg::TAP_W{prod_i_q[cdfir_pkg::PROD_W-1]}}, prod_i_q};
      acc_q_q <= acc_q_q + {{cdfir_pkg::TAP_W{prod_q_q[cdfir_pkg::PROD_W-1]}}, prod_q_q};
    end
  end

  // ------------------------------------------------------ round, saturate
  assign rnd_i  = (acc_i_q + cdfir_pkg::ROUND_HALF) >>> (cdfir_pkg::COEF_W - 1);
  assign rnd_q  = (acc_q_q + cdfir_pkg::ROUND_HALF) >>> (cdfir_pkg::COEF_W - 1);
  assign clip_i = (rnd_i > cdfir_pkg::OUT_MAX) || (rnd_i < cdfir_pkg::OUT_MIN);
  assign clip_q = (rnd_q > cdfir_pkg::OUT_MAX) || (rnd_q < cdfir_pkg::OUT_MIN);

  always_comb begin
    res_i = rnd_i[cdfir_pkg::SAMPLE_W-1:0];
    res_q = rnd_q[cdfir_pkg::SAMPLE_W-1:0];
    if (rnd_i > cdfir_pkg::OUT_MAX) res_i = cdfir_pkg::OUT_MAX[cdfir_pkg::SAMPLE_W-1:0];
    if (rnd_i < cdfir_pkg::OUT_MIN) res_i = cdfir_pkg::OUT_MIN[cdfir_pkg::SAMPLE_W-1:0];
    if (rnd_q > cdfir_pkg::OUT_MAX) res_q = cdfir_pkg::OUT_MAX[cdfir_pkg::SAMPLE_W-1:0];
    if (rnd_q < cdfir_pkg::OUT_MIN) res_q = cdfir_pkg::OUT_MIN[cdfir_pkg::SAMPLE_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (finish) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_i_q <= res_i;
      out_q_q <= res_q;
      sat_q   <= clip_i || clip_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_i_o     = out_i_q;
  assign out_q_o     = out_q_q;
  assign saturated_o = sat_q;

  // ------------------------------------------------------------- checks
  a_pipe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !(s1_q || s2_q))
    else $error("MAC pipeline busy while sequencer idle");

  a_coef_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    coef_acc |=> ($stable(phase_q) && $stable(wp_q)))
    else $error("coefficient beat moved the delay line or phase");

  a_fill_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= cdfir_pkg::CNT_W'(cdfir_pkg::MAX_TAPS))
    else $error("delay fill count overran");

  a_issue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |-> (k_q < taps_eff))
    else $error("tap issued beyond tap count");

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for complex_decimating_fir: directed and random I/Q and
// tap beats, an in-bench filter model and an in-order output check. Needs cdfir_pkg.
module tb_top;
  import cdfir_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
  localparam int SETTLE_CYCLES = MAX_TAPS + 16;
  localparam int STALL_LIMIT   = 4000;
  localparam int NUM_PHASES    = 8;
  localparam int PHASE_BEATS   = 50;

  typedef struct packed {
    logic                       mode;
    logic signed [SAMPLE_W-1:0] s_i;
    logic signed [SAMPLE_W-1:0] s_q;
    logic        [TAP_W-1:0]    idx;
    logic signed [COEF_W-1:0]   coef;
  } fir_beat_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] o_i;
    logic signed [SAMPLE_W-1:0] o_q;
    logic                       sat;
  } fir_out_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic                       mode_i;
  logic signed [SAMPLE_W-1:0] sample_i_i;
  logic signed [SAMPLE_W-1:0] sample_q_i;
  logic        [TAP_W-1:0]    coef_index_i;
  logic signed [COEF_W-1:0]   coef_value_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic signed [SAMPLE_W-1:0] out_i_o;
  logic signed [SAMPLE_W-1:0] out_q_o;
  logic                       saturated_o;
  logic                       cfg_valid_i;
  logic                       cfg_ready_o;
  logic        [CFG_IDX_W-1:0] cfg_index_i;
  logic        [CFG_DAT_W-1:0] cfg_data_i;

  // filter state mirrored in the bench
  logic signed [SAMPLE_W-1:0] dly_i    [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] dly_q    [MAX_TAPS];
  logic signed [COEF_W-1:0]   coef_mem [MAX_TAPS];
  logic        [DECIM_W-1:0]  decim_reg;
  logic        [CNT_W-1:0]    taps_reg;
  int unsigned                phase_cnt;

  fir_out_t due_outputs[$];
  fir_out_t head;
  int       mismatch_count;
  int       idle_cycles;
  bit       steady;

  complex_decimating_fir i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .sample_i_i   (sample_i_i),
    .sample_q_i   (sample_q_i),
    .coef_index_i (coef_index_i),
    .coef_value_i (coef_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_i_o      (out_i_o),
    .out_q_o      (out_q_o),
    .saturated_o  (saturated_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // round half up, drop the Q1.17 fraction, clip to the sample range
  function automatic logic signed [SAMPLE_W-1:0] round_clip(input longint acc,
                                                            inout logic clip);
    longint r;
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
    lo = -(longint'(1) <<< (SAMPLE_W - 1));
    r  = (acc + (longint'(1) <<< (COEF_W - 2))) >>> (COEF_W - 1);
    if (r > hi) begin
      r    = hi;
      clip = 1'b1;
    end else if (r < lo) begin
      r    = lo;
      clip = 1'b1;
    end
    return r[SAMPLE_W-1:0];
  endfunction

  task automatic shift_and_filter(input fir_beat_t b);
    int unsigned m;
    int unsigned taps;
    longint      acc_i;
    longint      acc_q;
    logic        clip;
    fir_out_t    res;
    if (b.mode == MODE_COEF) begin
      coef_mem[b.idx] = b.coef;
    end else begin
      for (int k = MAX_TAPS - 1; k > 0; k--) begin
        dly_i[k] = dly_i[k-1];
        dly_q[k] = dly_q[k-1];
      end
      dly_i[0] = b.s_i;
      dly_q[0] = b.s_q;
      m = (decim_reg == 0) ? 1 : (decim_reg > MAX_DECIM) ? MAX_DECIM : decim_reg;
      if (phase_cnt + 1 < m) begin
        phase_cnt++;
      end else begin
        phase_cnt = 0;
        taps  = (taps_reg > MAX_TAPS) ? MAX_TAPS : taps_reg;
        acc_i = 0;
        acc_q = 0;
        for (int k = 0; k < taps; k++) begin
          acc_i += longint'(coef_mem[k]) * longint'(dly_i[k]);
          acc_q += longint'(coef_mem[k]) * longint'(dly_q[k]);
        end
        clip    = 1'b0;
        res.o_i = round_clip(acc_i, clip);
        res.o_q = round_clip(acc_q, clip);
        res.sat = clip;
        due_outputs = {due_outputs, res};
      end
    end
  endtask

  function automatic fir_beat_t sample_beat(input logic signed [SAMPLE_W-1:0] si,
                                            input logic signed [SAMPLE_W-1:0] sq);
    fir_beat_t b;
    b.mode = MODE_SAMPLE;
    b.s_i  = si;
    b.s_q  = sq;
    b.idx  = TAP_W'($urandom);
    b.coef = COEF_W'($urandom);
    return b;
  endfunction

  function automatic fir_beat_t coef_beat(input logic [TAP_W-1:0] idx,
                                          input logic signed [COEF_W-1:0] val);
    fir_beat_t b;
    b.mode = MODE_COEF;
    b.s_i  = SAMPLE_W'($urandom);
    b.s_q  = SAMPLE_W'($urandom);
    b.idx  = idx;
    b.coef = val;
    return b;
  endfunction

  // called just after a rising edge; leaves valid high unless a gap is drawn
  task automatic push_beat(input fir_beat_t b);
    in_valid_i   <= 1'b1;
    mode_i       <= b.mode;
    sample_i_i   <= b.s_i;
    sample_q_i   <= b.s_q;
    coef_index_i <= b.idx;
    coef_value_i <= b.coef;
    do @(posedge clk_i); while (!in_ready_o);
    shift_and_filter(b);
    if (!steady && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DAT_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_DECIM) decim_reg = data[DECIM_W-1:0];
    else if (idx == CFG_TAPS) taps_reg = data[CNT_W-1:0];
  endtask

  task automatic configure(input logic [CFG_DAT_W-1:0] decim_data,
                           input logic [CFG_DAT_W-1:0] taps_data, input bit spare);
    write_reg(CFG_DECIM, decim_data);
    write_reg(CFG_TAPS, taps_data);
    if (spare) write_reg($urandom_range(0, 1) ? CFG_SPARE_B : CFG_SPARE_A,
                         CFG_DAT_W'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  // wait out every pending output plus the MAC pipeline before touching registers
  task automatic drain();
    in_valid_i <= 1'b0;
    while (due_outputs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic test_reset_state();
    push_beat(sample_beat(16'sd32767, -16'sd32768));
    push_beat(sample_beat(-16'sd32768, 16'sd32767));
    drain();
  endtask

  task automatic test_round_and_clip();
    configure(8'd1, 8'd2, 1'b0);
    push_beat(coef_beat(6'd0, -18'sd131072));
    push_beat(coef_beat(6'd1, 18'sd0));
    push_beat(sample_beat(-16'sd32768, 16'sd32767));
    push_beat(coef_beat(6'd0, 18'sd65536));
    push_beat(coef_beat(6'd1, 18'sd131071));
    push_beat(sample_beat(16'sd1, -16'sd1));
    push_beat(sample_beat(16'sd32767, -16'sd32768));
    push_beat(sample_beat(-16'sd1, 16'sd1));
    drain();
  endtask

  task automatic test_tap_count_edges();
    configure(8'd1, 8'd0, 1'b1);
    push_beat(sample_beat(16'sd12345, -16'sd54));
    drain();
    // 7-bit field above the store depth clamps to the full filter
    configure(8'd1, 8'hFF, 1'b0);
    push_beat(sample_beat(-16'sd300, 16'sd29000));
    drain();
  endtask

  task automatic test_decim_zero();
    configure(8'd0, 8'd64, 1'b0);
    push_beat(sample_beat(16'sd1000, 16'sd2000));
    drain();
  endtask

  task automatic test_decim_and_padding();
    configure(8'd3, 8'd7, 1'b0);
    push_beat(coef_beat(6'd6, 18'sd40000));
    push_beat(coef_beat(6'd63, -18'sd1));
    for (int n = 0; n < 5; n++)
      push_beat(sample_beat(SAMPLE_W'($urandom), SAMPLE_W'($urandom)));
    drain();
    // phase count sits at 2; a smaller ratio fires on the next sample
    configure(8'd2, 8'd7, 1'b0);
    push_beat(sample_beat(16'sd777, -16'sd777));
    drain();
  endtask

  task automatic test_random_phases();
    logic [CFG_DAT_W-1:0]       decim_data;
    logic [CFG_DAT_W-1:0]       taps_data;
    logic signed [SAMPLE_W-1:0] edge_vals [4];
    logic signed [SAMPLE_W-1:0] si;
    logic signed [SAMPLE_W-1:0] sq;
    logic signed [COEF_W-1:0]   cv;
    edge_vals = '{-16'sd32768, 16'sd32767, 16'sd0, -16'sd1};
    for (int p = 0; p < NUM_PHASES; p++) begin
      steady = (p == NUM_PHASES - 1);
      if (p == 0)
        decim_data = 8'hFF;
      else if (p == 1)
        decim_data = 8'd16;
      else if ($urandom_range(0, 4) == 0)
        decim_data = CFG_DAT_W'($urandom);
      else if ($urandom_range(0, 1) == 0)
        decim_data = CFG_DAT_W'($urandom_range(1, 4));
      else
        decim_data = CFG_DAT_W'($urandom_range(1, MAX_DECIM));
      if (p == 0)
        taps_data = 8'd64;
      else if ($urandom_range(0, 4) == 0)
        taps_data = CFG_DAT_W'($urandom);
      else
        taps_data = CFG_DAT_W'($urandom_range(1, MAX_TAPS));
      configure(decim_data, taps_data, $urandom_range(0, 3) == 0);
      if (p == 1) begin
        for (int k = 0; k < MAX_TAPS; k++) begin
          cv = COEF_W'($urandom);
          push_beat(coef_beat(TAP_W'(k), cv >>> $urandom_range(0, 10)));
        end
      end
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if ($urandom_range(0, 4) == 0) begin
          cv = COEF_W'($urandom);
          push_beat(coef_beat(TAP_W'($urandom), cv >>> $urandom_range(0, 10)));
        end else begin
          si = ($urandom_range(0, 9) == 0) ? edge_vals[$urandom_range(0, 3)]
                                           : SAMPLE_W'($urandom);
          sq = ($urandom_range(0, 9) == 0) ? edge_vals[$urandom_range(0, 3)]
                                           : SAMPLE_W'($urandom);
          push_beat(sample_beat(si, sq));
        end
      end
      drain();
    end
  endtask

  // output ready: random stall and run bursts, held high in steady mode
  initial begin
    int n;
    out_ready_i = 1'b1;
    forever begin
      n = $urandom_range(1, 16);
      if (!steady && $urandom_range(0, 2) == 0) out_ready_i <= 1'b0;
      else out_ready_i <= 1'b1;
      repeat (n) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (due_outputs.size() == 0) begin
        report_mismatch($sformatf("unexpected output beat i=%0d q=%0d sat=%0b",
                                  out_i_o, out_q_o, saturated_o));
      end else begin
        head = due_outputs.pop_front();
        if (out_i_o !== head.o_i)
          report_mismatch($sformatf("out_i got %0d want %0d", out_i_o, head.o_i));
        if (out_q_o !== head.o_q)
          report_mismatch($sformatf("out_q got %0d want %0d", out_q_o, head.o_q));
        if (saturated_o !== head.sat)
          report_mismatch($sformatf("saturated got %0b want %0b", saturated_o, head.sat));
      end
    end
  end

  // hang detector: too many cycles without any beat on any channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    mode_i         = MODE_SAMPLE;
    sample_i_i     = '0;
    sample_q_i     = '0;
    coef_index_i   = '0;
    coef_value_i   = '0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = CFG_DECIM;
    cfg_data_i     = '0;
    mismatch_count = 0;
    idle_cycles    = 0;
    steady         = 1'b0;
    decim_reg      = DECIM_RESET;
    taps_reg       = TAPS_RESET;
    phase_cnt      = 0;
    for (int k = 0; k < MAX_TAPS; k++) begin
      dly_i[k]    = '0;
      dly_q[k]    = '0;
      coef_mem[k] = '0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_round_and_clip();
    test_tap_count_edges();
    test_decim_zero();
    test_decim_and_padding();
    test_random_phases();

    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
